@@ rtl/core/rrm_pkg.sv @@
package rrm_pkg;

    localparam int NUM_AXES = 3;

    localparam int IN_WIDTH    = 32;
    localparam int OUT_WIDTH   = 64;
    localparam int DAMP_WIDTH  = 24;
    localparam int STIFF_WIDTH = 31;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;

    // fraction widths of the signal formats
    localparam int IN_RATE_FRAC   = 12;
    localparam int RATE_OUT_FRAC  = 36;
    localparam int ACCEL_OUT_FRAC = 36;
    localparam int REF_JERK_FRAC  = 32;
    localparam int VIRT_FRAC      = 12;
    localparam int UPDATE_SHIFT   = 9;

    // coefficient fraction widths
    localparam int DAMP_FRAC  = 10;
    localparam int STIFF_FRAC = 7;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_DAMP_ROLL   = 3'd0,
        REG_DAMP_PITCH  = 3'd1,
        REG_DAMP_YAW    = 3'd2,
        REG_STIFF_ROLL  = 3'd3,
        REG_STIFF_PITCH = 3'd4,
        REG_STIFF_YAW   = 3'd5
    } cfg_reg_t;

    typedef struct packed {
        logic [OUT_WIDTH-1:0] rate;
        logic [OUT_WIDTH-1:0] acc;
        logic [OUT_WIDTH-1:0] ff;
        logic [OUT_WIDTH-1:0] jerk;
    } axis_res_t;

    // right (arithmetic) for n >= 0, wrapping left for n < 0
    function automatic logic [63:0] fmt_shift(logic [63:0] x, int n);
        logic [63:0] r;
        if (n >= 64)
        begin
            r = {64{x[63]}};
        end
        else if (n >= 0)
        begin
            r = $unsigned($signed(x) >>> n);
        end
        else if (n <= -64)
        begin
            r = 64'd0;
        end
        else
        begin
            r = x << (-n);
        end
        return r;
    endfunction

    function automatic logic [63:0] sext32(logic [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    // low 64 bits of a 32-bit unsigned coefficient times a 64-bit word,
    // as two 32x32 partial products
    function automatic logic [63:0] mul_low(logic [31:0] a, logic [63:0] b);
        logic [63:0] lo;
        logic [63:0] hi;
        lo = {32'd0, a} * {32'd0, b[31:0]};
        hi = {32'd0, a} * {32'd0, b[63:32]};
        return lo + {hi[31:0], 32'd0};
    endfunction

endpackage

@@ rtl/core/rrm_in_if.sv @@
interface rrm_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] set_roll;
    logic [31:0] set_pitch;
    logic [31:0] set_yaw;
    logic [31:0] virt_roll;
    logic [31:0] virt_pitch;
    logic [31:0] virt_yaw;
    logic [31:0] got_roll;
    logic [31:0] got_pitch;
    logic [31:0] got_yaw;

    modport source (
        output valid, set_roll, set_pitch, set_yaw, virt_roll, virt_pitch, virt_yaw,
               got_roll, got_pitch, got_yaw,
        input  ready
    );
    modport sink (
        input  valid, set_roll, set_pitch, set_yaw, virt_roll, virt_pitch, virt_yaw,
               got_roll, got_pitch, got_yaw,
        output ready
    );
endinterface

@@ rtl/core/rrm_out_if.sv @@
interface rrm_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] ref_roll;
    logic [63:0] ref_pitch;
    logic [63:0] ref_yaw;
    logic [63:0] acc_roll;
    logic [63:0] acc_pitch;
    logic [63:0] acc_yaw;
    logic [63:0] ff_roll;
    logic [63:0] ff_pitch;
    logic [63:0] ff_yaw;
    logic [63:0] jerk_roll;
    logic [63:0] jerk_pitch;
    logic [63:0] jerk_yaw;

    modport source (
        output valid, ref_roll, ref_pitch, ref_yaw, acc_roll, acc_pitch, acc_yaw,
               ff_roll, ff_pitch, ff_yaw, jerk_roll, jerk_pitch, jerk_yaw,
        input  ready
    );
    modport sink (
        input  valid, ref_roll, ref_pitch, ref_yaw, acc_roll, acc_pitch, acc_yaw,
               ff_roll, ff_pitch, ff_yaw, jerk_roll, jerk_pitch, jerk_yaw,
        output ready
    );
endinterface

@@ rtl/core/rrm_cfg_if.sv @@
interface rrm_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [31:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

@@ rtl/core/rrm_axis.sv @@
module rrm_axis #(
    parameter int IN_RATE_FRAC   = rrm_pkg::IN_RATE_FRAC,
    parameter int RATE_OUT_FRAC  = rrm_pkg::RATE_OUT_FRAC,
    parameter int ACCEL_OUT_FRAC = rrm_pkg::ACCEL_OUT_FRAC,
    parameter int REF_JERK_FRAC  = rrm_pkg::REF_JERK_FRAC,
    parameter int VIRT_FRAC      = rrm_pkg::VIRT_FRAC,
    parameter int UPDATE_SHIFT   = rrm_pkg::UPDATE_SHIFT
) (
    input  logic [rrm_pkg::DAMP_WIDTH-1:0]  damp_coef,
    input  logic [rrm_pkg::STIFF_WIDTH-1:0] stiff_coef,
    input  logic [rrm_pkg::IN_WIDTH-1:0]    set_pt,
    input  logic [rrm_pkg::IN_WIDTH-1:0]    virt,
    input  logic [rrm_pkg::IN_WIDTH-1:0]    got,
    input  logic [rrm_pkg::OUT_WIDTH-1:0]   rate_q,
    input  logic [rrm_pkg::OUT_WIDTH-1:0]   accel_q,
    output rrm_pkg::axis_res_t              res
);

    logic [63:0] sp;
    logic [63:0] err;
    logic [63:0] ja_prod;
    logic [63:0] jr_prod;
    logic [63:0] ja;
    logic [63:0] jr;
    logic [63:0] jerk;
    logic [63:0] ff;
    logic [63:0] hedge;
    logic [63:0] acc;

    always_comb
    begin
        sp  = rrm_pkg::fmt_shift(rrm_pkg::sext32(set_pt), -(RATE_OUT_FRAC - IN_RATE_FRAC));
        err = sp - rate_q;

        // damping term uses -2*coef, so negate the product of 2*coef
        ja_prod = 64'd0 - rrm_pkg::mul_low({7'd0, damp_coef, 1'b0},
                      rrm_pkg::fmt_shift(accel_q, ACCEL_OUT_FRAC - REF_JERK_FRAC));
        jr_prod = rrm_pkg::mul_low({1'b0, stiff_coef},
                      rrm_pkg::fmt_shift(err, RATE_OUT_FRAC - REF_JERK_FRAC));
        ja   = rrm_pkg::fmt_shift(ja_prod, rrm_pkg::DAMP_FRAC);
        jr   = rrm_pkg::fmt_shift(jr_prod, rrm_pkg::STIFF_FRAC);
        jerk = ja + jr;

        ff = accel_q + rrm_pkg::fmt_shift(jerk,
                 UPDATE_SHIFT + REF_JERK_FRAC - ACCEL_OUT_FRAC);

        hedge = rrm_pkg::fmt_shift(rrm_pkg::sext32(virt), -(ACCEL_OUT_FRAC - VIRT_FRAC))
              - rrm_pkg::fmt_shift(rrm_pkg::sext32(got), -(ACCEL_OUT_FRAC - IN_RATE_FRAC));
        acc = ff - hedge;

        res.rate = rate_q + rrm_pkg::fmt_shift(acc,
                       UPDATE_SHIFT + ACCEL_OUT_FRAC - RATE_OUT_FRAC);
        res.acc  = acc;
        res.ff   = ff;
        res.jerk = jerk;
    end

endmodule

@@ rtl/core/rate_reference_model_with_hedge.sv @@
// channel  modport  carries
// tick     sink     rate setpoints, virtual inputs, achieved accelerations per axis
// result   source   reference rate, hedged accel, feedforward, jerk per axis
// cfg      sink     register index and data for the six axis coefficients
//
// one request per cycle while the result is not stalled
// the input register feeds the three axis datapaths, which update the rate and
// accel state and load the result register in one pass
// rst_n clears the coefficients, the axis state and both valid flags
// a stalled result holds the output register; one more request still enters
// the input register, then tick.ready drops
module rate_reference_model_with_hedge #(
    parameter int IN_RATE_FRAC   = rrm_pkg::IN_RATE_FRAC,
    parameter int RATE_OUT_FRAC  = rrm_pkg::RATE_OUT_FRAC,
    parameter int ACCEL_OUT_FRAC = rrm_pkg::ACCEL_OUT_FRAC,
    parameter int REF_JERK_FRAC  = rrm_pkg::REF_JERK_FRAC,
    parameter int VIRT_FRAC      = rrm_pkg::VIRT_FRAC,
    parameter int UPDATE_SHIFT   = rrm_pkg::UPDATE_SHIFT
) (
    input  logic      clk,
    input  logic      rst_n,
    rrm_in_if.sink    tick,
    rrm_out_if.source result,
    rrm_cfg_if.sink   cfg
);

    localparam int NA = rrm_pkg::NUM_AXES;

    logic [rrm_pkg::DAMP_WIDTH-1:0]  damp_reg  [NA];
    logic [rrm_pkg::STIFF_WIDTH-1:0] stiff_reg [NA];
    logic [rrm_pkg::OUT_WIDTH-1:0]   rate_reg  [NA];
    logic [rrm_pkg::OUT_WIDTH-1:0]   accel_reg [NA];

    logic [rrm_pkg::IN_WIDTH-1:0] set_reg  [NA];
    logic [rrm_pkg::IN_WIDTH-1:0] virt_reg [NA];
    logic [rrm_pkg::IN_WIDTH-1:0] got_reg  [NA];
    logic                         s1_valid_reg;

    rrm_pkg::axis_res_t res_next [NA];
    rrm_pkg::axis_res_t res_reg  [NA];
    logic               out_valid_reg;

    logic out_free;
    logic s1_fire;
    logic in_fire;

    assign out_free   = !out_valid_reg || result.ready;
    assign s1_fire    = s1_valid_reg && out_free;
    assign tick.ready = !s1_valid_reg || out_free;
    assign in_fire    = tick.valid && tick.ready;
    assign cfg.ready  = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                damp_reg[i]  <= '0;
                stiff_reg[i] <= '0;
            end
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                rrm_pkg::REG_DAMP_ROLL:   damp_reg[0]  <= cfg.data[rrm_pkg::DAMP_WIDTH-1:0];
                rrm_pkg::REG_DAMP_PITCH:  damp_reg[1]  <= cfg.data[rrm_pkg::DAMP_WIDTH-1:0];
                rrm_pkg::REG_DAMP_YAW:    damp_reg[2]  <= cfg.data[rrm_pkg::DAMP_WIDTH-1:0];
                rrm_pkg::REG_STIFF_ROLL:  stiff_reg[0] <= cfg.data[rrm_pkg::STIFF_WIDTH-1:0];
                rrm_pkg::REG_STIFF_PITCH: stiff_reg[1] <= cfg.data[rrm_pkg::STIFF_WIDTH-1:0];
                rrm_pkg::REG_STIFF_YAW:   stiff_reg[2] <= cfg.data[rrm_pkg::STIFF_WIDTH-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            set_reg[0]  <= tick.set_roll;
            set_reg[1]  <= tick.set_pitch;
            set_reg[2]  <= tick.set_yaw;
            virt_reg[0] <= tick.virt_roll;
            virt_reg[1] <= tick.virt_pitch;
            virt_reg[2] <= tick.virt_yaw;
            got_reg[0]  <= tick.got_roll;
            got_reg[1]  <= tick.got_pitch;
            got_reg[2]  <= tick.got_yaw;
        end
    end

    for (genvar a = 0; a < NA; a++)
    begin : g_axis
        rrm_axis #(
            .IN_RATE_FRAC   (IN_RATE_FRAC),
            .RATE_OUT_FRAC  (RATE_OUT_FRAC),
            .ACCEL_OUT_FRAC (ACCEL_OUT_FRAC),
            .REF_JERK_FRAC  (REF_JERK_FRAC),
            .VIRT_FRAC      (VIRT_FRAC),
            .UPDATE_SHIFT   (UPDATE_SHIFT)
        ) u_axis (
            .damp_coef  (damp_reg[a]),
            .stiff_coef (stiff_reg[a]),
            .set_pt     (set_reg[a]),
            .virt       (virt_reg[a]),
            .got        (got_reg[a]),
            .rate_q     (rate_reg[a]),
            .accel_q    (accel_reg[a]),
            .res        (res_next[a])
        );
    end

    // axis state advances together with the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NA; i++)
            begin
                rate_reg[i]  <= '0;
                accel_reg[i] <= '0;
            end
        end
        else if (s1_fire)
        begin
            for (int i = 0; i < NA; i++)
            begin
                rate_reg[i]  <= res_next[i].rate;
                accel_reg[i] <= res_next[i].acc;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire)
        begin
            for (int i = 0; i < NA; i++)
            begin
                res_reg[i] <= res_next[i];
            end
        end
    end

    assign result.valid      = out_valid_reg;
    assign result.ref_roll   = res_reg[0].rate;
    assign result.ref_pitch  = res_reg[1].rate;
    assign result.ref_yaw    = res_reg[2].rate;
    assign result.acc_roll   = res_reg[0].acc;
    assign result.acc_pitch  = res_reg[1].acc;
    assign result.acc_yaw    = res_reg[2].acc;
    assign result.ff_roll    = res_reg[0].ff;
    assign result.ff_pitch   = res_reg[1].ff;
    assign result.ff_yaw     = res_reg[2].ff;
    assign result.jerk_roll  = res_reg[0].jerk;
    assign result.jerk_pitch = res_reg[1].jerk;
    assign result.jerk_yaw   = res_reg[2].jerk;

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;

    localparam int DRAIN_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int PHASES        = 6;
    localparam int PHASE_TICKS   = 205;
    localparam int DIRECTED_ROWS = 18;
    localparam int LONG_HOLD     = 300;
    localparam int NUM_CFG_SLOTS = 8;
    localparam int NAX           = rrm_pkg::NUM_AXES;
    localparam int INW           = rrm_pkg::IN_WIDTH;

    typedef struct packed {
        logic [NAX-1:0][INW-1:0] set;
        logic [NAX-1:0][INW-1:0] virt;
        logic [NAX-1:0][INW-1:0] got;
    } tick_t;

    typedef rrm_pkg::axis_res_t [NAX-1:0] step_res_t;

    typedef struct packed {
        logic      on;
        step_res_t want;
    } pin_t;

    typedef struct packed {
        int        cfg_set;
        tick_t     t;
        logic      on;
        step_res_t want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    rrm_in_if  tick_if ();
    rrm_out_if res_if ();
    rrm_cfg_if cfg_if ();

    rate_reference_model_with_hedge uut (
        .clk    (clk),
        .rst_n  (rst_n),
        .tick   (tick_if),
        .result (res_if),
        .cfg    (cfg_if)
    );

    always #5 clk = ~clk;

    // shadow of the block state and coefficients
    logic [rrm_pkg::OUT_WIDTH-1:0]   rate_st [NAX];
    logic [rrm_pkg::OUT_WIDTH-1:0]   accel_st [NAX];
    logic [rrm_pkg::DAMP_WIDTH-1:0]  damp_cf [NAX];
    logic [rrm_pkg::STIFF_WIDTH-1:0] stiff_cf [NAX];

    step_res_t pending_refs [$];
    pin_t      pinned_refs [$];

    logic [rrm_pkg::CFG_DATA_W-1:0] coef_word [NUM_CFG_SLOTS];
    logic [rrm_pkg::CFG_DATA_W-1:0] cfg_sets [3][NUM_CFG_SLOTS];
    logic [INW-1:0]                 held_set [NAX];
    row_t                           steps [DIRECTED_ROWS];
    string                          axis_name [NAX] = '{"roll", "pitch", "yaw"};

    int mismatches = 0;
    int ticks_in = 0;
    int results_out = 0;
    int cfg_writes = 0;
    int settings_used = 0;
    int cycles = 0;
    int hold_len = 0;

    initial
    begin
        for (int ax = 0; ax < NAX; ax++)
        begin
            rate_st[ax] = '0;
            accel_st[ax] = '0;
            damp_cf[ax] = '0;
            stiff_cf[ax] = '0;
            held_set[ax] = '0;
        end
    end

    // positive count: arithmetic right shift, negative: wrapping left shift
    function automatic logic [63:0] rescale(logic [63:0] v, int sh);
        logic [63:0] r;
        if (sh < 0)
        begin
            r = (sh < -63) ? 64'd0 : (v << (-sh));
        end
        else if (sh > 63)
        begin
            r = v[63] ? '1 : '0;
        end
        else
        begin
            r = $signed(v) >>> sh;
        end
        return r;
    endfunction

    function automatic step_res_t advance_reference(tick_t t);
        step_res_t r;
        logic [63:0] sp, err, dneg, ja, jr, jerk, ff, hedge, acc, vx, gx, sx;
        for (int ax = 0; ax < NAX; ax++)
        begin
            sx = {{32{t.set[ax][31]}}, t.set[ax]};
            vx = {{32{t.virt[ax][31]}}, t.virt[ax]};
            gx = {{32{t.got[ax][31]}}, t.got[ax]};
            sp = rescale(sx, rrm_pkg::IN_RATE_FRAC - rrm_pkg::RATE_OUT_FRAC);
            err = sp - rate_st[ax];
            dneg = 64'd0 - ({40'd0, damp_cf[ax]} << 1);
            ja = rescale(dneg * rescale(accel_st[ax],
                                        rrm_pkg::ACCEL_OUT_FRAC - rrm_pkg::REF_JERK_FRAC),
                         rrm_pkg::DAMP_FRAC);
            jr = rescale({33'd0, stiff_cf[ax]} *
                         rescale(err, rrm_pkg::RATE_OUT_FRAC - rrm_pkg::REF_JERK_FRAC),
                         rrm_pkg::STIFF_FRAC);
            jerk = ja + jr;
            ff = accel_st[ax] + rescale(jerk, rrm_pkg::UPDATE_SHIFT + rrm_pkg::REF_JERK_FRAC
                                              - rrm_pkg::ACCEL_OUT_FRAC);
            hedge = rescale(vx, rrm_pkg::VIRT_FRAC - rrm_pkg::ACCEL_OUT_FRAC) -
                    rescale(gx, rrm_pkg::IN_RATE_FRAC - rrm_pkg::ACCEL_OUT_FRAC);
            acc = ff - hedge;
            accel_st[ax] = acc;
            rate_st[ax] = rate_st[ax] +
                          rescale(acc, rrm_pkg::UPDATE_SHIFT + rrm_pkg::ACCEL_OUT_FRAC
                                       - rrm_pkg::RATE_OUT_FRAC);
            r[ax].rate = rate_st[ax];
            r[ax].acc = acc;
            r[ax].ff = ff;
            r[ax].jerk = jerk;
        end
        return r;
    endfunction

    task automatic flag_mismatch(string what, logic [63:0] seen, logic [63:0] want);
        $display("mismatch at %0t: %s got %h want %h", $time, what, seen, want);
        mismatches++;
    endtask

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("[rate_reference_model_with_hedge] ERROR");
            $finish;
        end
    end

    // accepted tick request: advance the shadow state and queue the expected result
    always @(posedge clk)
    begin
        if (rst_n && tick_if.valid && tick_if.ready)
        begin
            tick_t     t;
            pin_t      p;
            step_res_t r;
            t.set[0]  = tick_if.set_roll;
            t.set[1]  = tick_if.set_pitch;
            t.set[2]  = tick_if.set_yaw;
            t.virt[0] = tick_if.virt_roll;
            t.virt[1] = tick_if.virt_pitch;
            t.virt[2] = tick_if.virt_yaw;
            t.got[0]  = tick_if.got_roll;
            t.got[1]  = tick_if.got_pitch;
            t.got[2]  = tick_if.got_yaw;
            r = advance_reference(t);
            if (pinned_refs.size() != 0)
            begin
                p = pinned_refs.pop_front();
                if (p.on)
                    r = p.want;
            end
            pending_refs.push_back(r);
            ticks_in++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && cfg_if.valid && cfg_if.ready)
        begin
            logic [rrm_pkg::CFG_IDX_W-1:0] sidx;
            sidx = cfg_if.index - rrm_pkg::REG_STIFF_ROLL;
            if (cfg_if.index < rrm_pkg::REG_STIFF_ROLL)
                damp_cf[cfg_if.index[1:0]] = cfg_if.data[rrm_pkg::DAMP_WIDTH-1:0];
            else if (cfg_if.index <= rrm_pkg::REG_STIFF_YAW)
                stiff_cf[sidx[1:0]] = cfg_if.data[rrm_pkg::STIFF_WIDTH-1:0];
            cfg_writes++;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_if.valid && res_if.ready)
        begin
            step_res_t seen;
            step_res_t want;
            seen[0].rate = res_if.ref_roll;
            seen[1].rate = res_if.ref_pitch;
            seen[2].rate = res_if.ref_yaw;
            seen[0].acc  = res_if.acc_roll;
            seen[1].acc  = res_if.acc_pitch;
            seen[2].acc  = res_if.acc_yaw;
            seen[0].ff   = res_if.ff_roll;
            seen[1].ff   = res_if.ff_pitch;
            seen[2].ff   = res_if.ff_yaw;
            seen[0].jerk = res_if.jerk_roll;
            seen[1].jerk = res_if.jerk_pitch;
            seen[2].jerk = res_if.jerk_yaw;
            results_out++;
            if (pending_refs.size() == 0)
            begin
                flag_mismatch("result with nothing pending, ref_roll", seen[0].rate, '0);
            end
            else
            begin
                want = pending_refs.pop_front();
                for (int ax = 0; ax < NAX; ax++)
                begin
                    if (seen[ax].rate !== want[ax].rate)
                        flag_mismatch({"ref_", axis_name[ax]}, seen[ax].rate, want[ax].rate);
                    if (seen[ax].acc !== want[ax].acc)
                        flag_mismatch({"acc_", axis_name[ax]}, seen[ax].acc, want[ax].acc);
                    if (seen[ax].ff !== want[ax].ff)
                        flag_mismatch({"ff_", axis_name[ax]}, seen[ax].ff, want[ax].ff);
                    if (seen[ax].jerk !== want[ax].jerk)
                        flag_mismatch({"jerk_", axis_name[ax]}, seen[ax].jerk, want[ax].jerk);
                end
            end
        end
    end

    // result side: stall pattern is redrawn periodically, long hold on request
    initial
    begin
        int stall_pct;
        int hold_cnt;
        int beat;
        stall_pct = 0;
        hold_cnt = 0;
        beat = 0;
        res_if.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            beat++;
            if (hold_len > 0)
            begin
                hold_cnt = hold_len;
                hold_len = 0;
            end
            if (beat % 48 == 0)
            begin
                case ($urandom_range(0, 3))
                    0, 1:    stall_pct = 0;
                    2:       stall_pct = 35;
                    default: stall_pct = 75;
                endcase
            end
            if (hold_cnt > 0)
            begin
                res_if.ready <= 1'b0;
                hold_cnt--;
            end
            else
            begin
                res_if.ready <= ($urandom_range(0, 99) >= stall_pct);
            end
        end
    end

    function automatic logic [31:0] boundary_word();
        logic [31:0] w;
        case ($urandom_range(0, 4))
            0:       w = 32'h8000_0000;
            1:       w = 32'h7FFF_FFFF;
            2:       w = 32'h0000_0000;
            3:       w = 32'hFFFF_FFFF;
            default: w = 32'h0000_0001;
        endcase
        return w;
    endfunction

    // mostly held setpoints with small hedge terms, some full-range and boundary words
    function automatic tick_t random_tick();
        tick_t t;
        int    mode;
        for (int ax = 0; ax < NAX; ax++)
        begin
            mode = $urandom_range(0, 99);
            if (mode < 60)
            begin
                if ($urandom_range(0, 19) == 0)
                    held_set[ax] = $urandom_range(0, 65535) - 32768;
                t.set[ax] = held_set[ax];
                t.virt[ax] = $urandom_range(0, 32767) - 16384;
                t.got[ax] = t.virt[ax] + $urandom_range(0, 511) - 256;
            end
            else if (mode < 85)
            begin
                t.set[ax] = $urandom();
                t.virt[ax] = $urandom();
                t.got[ax] = $urandom();
            end
            else
            begin
                t.set[ax] = boundary_word();
                t.virt[ax] = boundary_word();
                t.got[ax] = boundary_word();
            end
        end
        return t;
    endfunction

    function automatic row_t mk_row(int cs, logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                                    logic [31:0] v0, logic [31:0] v1, logic [31:0] v2,
                                    logic [31:0] g0, logic [31:0] g1, logic [31:0] g2);
        row_t r;
        r = '0;
        r.cfg_set = cs;
        r.t.set[0] = s0;
        r.t.set[1] = s1;
        r.t.set[2] = s2;
        r.t.virt[0] = v0;
        r.t.virt[1] = v1;
        r.t.virt[2] = v2;
        r.t.got[0] = g0;
        r.t.got[1] = g1;
        r.t.got[2] = g2;
        return r;
    endfunction

    task automatic offer_tick(tick_t t);
        tick_if.valid      <= 1'b1;
        tick_if.set_roll   <= t.set[0];
        tick_if.set_pitch  <= t.set[1];
        tick_if.set_yaw    <= t.set[2];
        tick_if.virt_roll  <= t.virt[0];
        tick_if.virt_pitch <= t.virt[1];
        tick_if.virt_yaw   <= t.virt[2];
        tick_if.got_roll   <= t.got[0];
        tick_if.got_pitch  <= t.got[1];
        tick_if.got_yaw    <= t.got[2];
        @(posedge clk);
        while (!tick_if.ready) @(posedge clk);
    endtask

    task automatic idle_tick(int n);
        if (n > 0)
        begin
            tick_if.valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
    endtask

    // stop sending and let every pending result come back
    task automatic settle();
        tick_if.valid <= 1'b0;
        while (pending_refs.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic load_coefs(int nregs);
        for (int i = 0; i < nregs; i++)
        begin
            cfg_if.valid <= 1'b1;
            cfg_if.index <= i[rrm_pkg::CFG_IDX_W-1:0];
            cfg_if.data  <= coef_word[i];
            @(posedge clk);
            while (!cfg_if.ready) @(posedge clk);
        end
        cfg_if.valid <= 1'b0;
        settings_used++;
    endtask

    initial
    begin
        int cur_set;
        int n;
        int burst;
        int gap;
        int kind;
        pin_t p;

        tick_if.valid = 1'b0;
        tick_if.set_roll = '0;
        tick_if.set_pitch = '0;
        tick_if.set_yaw = '0;
        tick_if.virt_roll = '0;
        tick_if.virt_pitch = '0;
        tick_if.virt_yaw = '0;
        tick_if.got_roll = '0;
        tick_if.got_pitch = '0;
        tick_if.got_yaw = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = rrm_pkg::REG_DAMP_ROLL;
        cfg_if.data = '0;

        // set 1: all-ones words, so the excess bits are dropped; spare indexes too
        // set 2: moderate gains
        for (int i = 0; i < NUM_CFG_SLOTS; i++)
        begin
            cfg_sets[0][i] = '0;
            cfg_sets[1][i] = 32'hFFFF_FFFF;
        end
        cfg_sets[2][rrm_pkg::REG_DAMP_ROLL]   = 32'd46080;
        cfg_sets[2][rrm_pkg::REG_DAMP_PITCH]  = 32'd30000;
        cfg_sets[2][rrm_pkg::REG_DAMP_YAW]    = 32'd12000;
        cfg_sets[2][rrm_pkg::REG_STIFF_ROLL]  = 32'd320000;
        cfg_sets[2][rrm_pkg::REG_STIFF_PITCH] = 32'd200000;
        cfg_sets[2][rrm_pkg::REG_STIFF_YAW]   = 32'd64000;
        for (int i = rrm_pkg::REG_STIFF_YAW + 1; i < NUM_CFG_SLOTS; i++)
            cfg_sets[2][i] = '0;

        steps[0]  = mk_row(0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        steps[1]  = mk_row(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
        steps[2]  = mk_row(0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        steps[3]  = mk_row(0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        steps[4]  = mk_row(0, 0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        steps[5]  = mk_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0);
        steps[6]  = mk_row(1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0);
        steps[7]  = mk_row(1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        steps[8]  = mk_row(1, 0, 0, 0, 0, 0, 0, 0, 0, 0);
        steps[9]  = mk_row(1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        for (int r = 10; r < 15; r++)
            steps[r] = mk_row(2, 32'h1000, 32'h1000, 32'h1000, 0, 0, 0, 0, 0, 0);
        steps[15] = mk_row(2, 0, 0, 0, 32'h800, 32'h800, 32'h800, 32'h400, 32'h400, 32'h400);
        steps[16] = mk_row(2, 32'hFFFF_F000, 32'hFFFF_F000, 32'hFFFF_F000,
                           32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                           32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        steps[17] = mk_row(2, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 1, 1,
                           32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // zero gains from reset: the hedge alone drives accel and rate
        steps[0].on = 1'b1;
        steps[1].on = 1'b1;
        steps[1].want[0].acc  = 64'hFFFF_FFFF_FF00_0000;
        steps[1].want[0].rate = 64'hFFFF_FFFF_FFFF_8000;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        cur_set = 0;
        for (int r = 0; r < DIRECTED_ROWS; r++)
        begin
            if (steps[r].cfg_set != cur_set)
            begin
                settle();
                cur_set = steps[r].cfg_set;
                for (int i = 0; i < NUM_CFG_SLOTS; i++)
                    coef_word[i] = cfg_sets[cur_set][i];
                load_coefs(cur_set == 1 ? NUM_CFG_SLOTS : rrm_pkg::REG_STIFF_YAW + 1);
            end
            p.on = steps[r].on;
            p.want = steps[r].want;
            pinned_refs.push_back(p);
            offer_tick(steps[r].t);
            idle_tick($urandom_range(0, 2));
        end

        for (int ph = 0; ph < PHASES; ph++)
        begin
            settle();
            kind = ph % 4;
            for (int i = 0; i < NUM_CFG_SLOTS; i++)
            begin
                case (kind)
                    0: coef_word[i] = (i < rrm_pkg::REG_STIFF_ROLL)
                                      ? $urandom_range(1000, 100000)
                                      : $urandom_range(10000, 2000000);
                    1: coef_word[i] = 32'hFFFF_FFFF;
                    2: coef_word[i] = '0;
                    default: coef_word[i] = $urandom();
                endcase
            end
            load_coefs((kind == 0 || kind == 2) ? rrm_pkg::REG_STIFF_YAW + 1 : NUM_CFG_SLOTS);
            n = 0;
            while (n < PHASE_TICKS)
            begin
                burst = $urandom_range(1, 24);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                for (int k = 0; k < burst && n < PHASE_TICKS; k++)
                begin
                    offer_tick(random_tick());
                    n++;
                    // result side holds off while ticks keep coming
                    if (n == PHASE_TICKS / 2 && ph % 3 == 0)
                        hold_len = LONG_HOLD;
                    if (n == PHASE_TICKS - 40 && ph == 2)
                        settle();
                end
                idle_tick(gap);
            end
        end

        tick_if.valid <= 1'b0;
        n = 0;
        while (pending_refs.size() != 0 && n < 5000)
        begin
            @(posedge clk);
            n++;
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_refs.size() != 0)
            flag_mismatch("results never returned, count", pending_refs.size(), '0);

        $display("%0d tick requests, %0d results checked, %0d mismatches", ticks_in,
                 results_out, mismatches);
        $display("%0d coefficient writes over %0d gain settings incl. zero, full-scale, spare",
                 cfg_writes, settings_used);
        if (mismatches == 0)
            $display("[rate_reference_model_with_hedge] OK");
        else
            $display("[rate_reference_model_with_hedge] ERROR");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/rrm_pkg.sv
rtl/core/rrm_in_if.sv
rtl/core/rrm_out_if.sv
rtl/core/rrm_cfg_if.sv
rtl/core/rrm_axis.sv
rtl/core/rate_reference_model_with_hedge.sv
dv/testbench.sv
